// ===== rtl/shcfr_pkg.sv =====
// Shared types and constants for the sync-header CRC frame receiver.
// Self-contained; imported by every module in rtl/.
package shcfr_pkg;

	// sync pair and header layout
	localparam logic [7:0]  SYNC_FIRST    = 8'h56;   // 'V'
	localparam logic [7:0]  SYNC_SECOND   = 8'h4C;   // 'L'
	localparam logic [3:0]  HDR_LAST_POS  = 4'd15;
	localparam logic [15:0] HDR_BYTES     = 16'd16;
	localparam logic [15:0] MIN_PAYLOAD   = 16'd14;
	localparam logic [7:0]  HDR_VERSION   = 8'd1;
	localparam logic [7:0]  HDR_TYPE      = 8'd1;

	// header byte positions
	localparam logic [3:0] POS_VERSION = 4'd2;
	localparam logic [3:0] POS_TYPE    = 4'd3;
	localparam logic [3:0] POS_HLEN_LO = 4'd4;
	localparam logic [3:0] POS_HLEN_HI = 4'd5;
	localparam logic [3:0] POS_PLEN_LO = 4'd6;
	localparam logic [3:0] POS_PLEN_HI = 4'd7;
	localparam logic [3:0] POS_CRC_B0  = 4'd12;
	localparam logic [3:0] POS_CRC_B1  = 4'd13;
	localparam logic [3:0] POS_CRC_B2  = 4'd14;
	localparam logic [3:0] POS_CRC_B3  = 4'd15;

	// CRC-32, reflected
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1514;

	typedef enum logic [2:0] {
		EV_PAYLOAD  = 3'd0,
		EV_LAST_OK  = 3'd1,
		EV_LAST_CRC = 3'd2,
		EV_BAD_SYNC = 3'd3,
		EV_BAD_VER  = 3'd4,
		EV_BAD_LEN  = 3'd5
	} event_t;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_SECOND  = 4'b0010,
		PH_HEADER  = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

endpackage

// ===== rtl/shcfr_crc_byte.sv =====
// One-byte update of the reflected CRC-32 (polynomial 0xEDB88320).
// Depends on shcfr_pkg for the polynomial.
module shcfr_crc_byte (
	input  logic [31:0] crc_in,
	input  logic [7:0]  data_in,
	output logic [31:0] crc_out
);
	import shcfr_pkg::*;

	always_comb begin
		logic [31:0] c;
		c = crc_in ^ {24'd0, data_in};
		for (int i = 0; i < 8; i++) begin
			c = {1'b0, c[31:1]} ^ (CRC_POLY & {32{c[0]}});
		end
		crc_out = c;
	end

endmodule

// ===== rtl/sync_header_crc_frame_receiver.sv =====
// Sync-header CRC frame receiver: top level with input stage, frame parser and result register.
// Depends on shcfr_pkg and shcfr_crc_byte.
//
// Path: an accepted byte is held in the input register, parsed combinationally, and
//   its result beat, if any, is loaded into the result register when the parser advances.
// Throughput: one byte per cycle unless the output side stalls; the parser state and the
//   byte-wide CRC update are combinational between the input and result registers.
// Reset (arst_n low, asynchronous): hunt for 'V', counters and header fields cleared,
//   running CRC all ones, max payload length 1514, both stages empty.
module sync_header_crc_frame_receiver (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: max payload length
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// byte input
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// result output
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic        last
);
	import shcfr_pkg::*;

	// ---------------------------------------------------------------
	// Configuration register
	// ---------------------------------------------------------------
	logic [15:0] max_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			max_payload_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// Input stage: hold one byte until the parser can take it.
	// The parser advances whenever the result register is free or
	// being drained this cycle, so a new beat is taken every cycle
	// unless the output side stalls.
	// ---------------------------------------------------------------
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       in_acc;

	assign adv      = valid_s1 && (!out_valid || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1 <= rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// Parser state
	// ---------------------------------------------------------------
	phase_t      phase_q,        phase_d;
	logic [3:0]  header_count_q, header_count_d;
	logic [7:0]  version_q,      version_d;
	logic [7:0]  type_q,         type_d;
	logic [15:0] hdr_len_q,      hdr_len_d;
	logic [15:0] pay_len_q,      pay_len_d;
	logic [31:0] exp_crc_q,      exp_crc_d;
	logic [15:0] pay_cnt_q,      pay_cnt_d;
	logic [31:0] run_crc_q,      run_crc_d;

	logic [31:0] crc_next;
	logic [15:0] cnt_inc;

	// result of the byte in the input stage
	logic        res_valid;
	event_t      res_ev;
	logic [7:0]  res_data;
	logic        res_last;

	shcfr_crc_byte u_crc (
		.crc_in  (run_crc_q),
		.data_in (byte_s1),
		.crc_out (crc_next)
	);

	assign cnt_inc = pay_cnt_q + 16'd1;

	always_comb begin
		phase_d        = phase_q;
		header_count_d = header_count_q;
		version_d      = version_q;
		type_d         = type_q;
		hdr_len_d      = hdr_len_q;
		pay_len_d      = pay_len_q;
		exp_crc_d      = exp_crc_q;
		pay_cnt_d      = pay_cnt_q;
		run_crc_d      = run_crc_q;
		res_valid      = 1'b0;
		res_ev         = EV_PAYLOAD;
		res_data       = 8'd0;
		res_last       = 1'b0;

		unique case (phase_q)
			PH_HUNT: begin
				if (byte_s1 == SYNC_FIRST) begin
					phase_d        = PH_SECOND;
					header_count_d = 4'd1;
				end else begin
					res_valid = 1'b1;
					res_ev    = EV_BAD_SYNC;
				end
			end
			PH_SECOND: begin
				if (byte_s1 == SYNC_SECOND) begin
					phase_d        = PH_HEADER;
					header_count_d = POS_VERSION;
				end else if (byte_s1 == SYNC_FIRST) begin
					// a repeated 'V' re-syncs
					header_count_d = 4'd1;
				end else begin
					phase_d        = PH_HUNT;
					header_count_d = 4'd0;
					res_valid      = 1'b1;
					res_ev         = EV_BAD_SYNC;
				end
			end
			PH_HEADER: begin
				// capture little-endian header fields; flags are skipped
				unique case (header_count_q)
					POS_VERSION: version_d = byte_s1;
					POS_TYPE:    type_d    = byte_s1;
					POS_HLEN_LO: hdr_len_d = {hdr_len_q[15:8], byte_s1};
					POS_HLEN_HI: hdr_len_d = {byte_s1, hdr_len_q[7:0]};
					POS_PLEN_LO: pay_len_d = {pay_len_q[15:8], byte_s1};
					POS_PLEN_HI: pay_len_d = {byte_s1, pay_len_q[7:0]};
					POS_CRC_B0:  exp_crc_d = {exp_crc_q[31:8], byte_s1};
					POS_CRC_B1:  exp_crc_d = {exp_crc_q[31:16], byte_s1, exp_crc_q[7:0]};
					POS_CRC_B2:  exp_crc_d = {exp_crc_q[31:24], byte_s1, exp_crc_q[15:0]};
					POS_CRC_B3:  exp_crc_d = {byte_s1, exp_crc_q[23:0]};
					default:     ;
				endcase

				if (header_count_q != HDR_LAST_POS) begin
					header_count_d = header_count_q + 4'd1;
				end else if (version_q != HDR_VERSION || type_q != HDR_TYPE) begin
					// version or type wins over a length fault
					phase_d        = PH_HUNT;
					header_count_d = 4'd0;
					res_valid      = 1'b1;
					res_ev         = EV_BAD_VER;
				end else if (hdr_len_q != HDR_BYTES || pay_len_q < MIN_PAYLOAD ||
						pay_len_q > max_payload_q) begin
					phase_d        = PH_HUNT;
					header_count_d = 4'd0;
					res_valid      = 1'b1;
					res_ev         = EV_BAD_LEN;
				end else begin
					phase_d        = PH_PAYLOAD;
					header_count_d = 4'd0;
					pay_cnt_d      = 16'd0;
					run_crc_d      = CRC_INIT;
				end
			end
			PH_PAYLOAD: begin
				run_crc_d = crc_next;
				pay_cnt_d = cnt_inc;
				res_valid = 1'b1;
				res_data  = byte_s1;
				if (cnt_inc < pay_len_q) begin
					res_ev = EV_PAYLOAD;
				end else begin
					// final byte: compare the finished CRC, then hunt again
					phase_d        = PH_HUNT;
					header_count_d = 4'd0;
					res_last       = 1'b1;
					res_ev         = (crc_next == exp_crc_q) ? EV_LAST_OK : EV_LAST_CRC;
				end
			end
			default: begin
				phase_d        = PH_HUNT;
				header_count_d = 4'd0;
			end
		endcase
	end

	// advance the parser state only when the byte in the input stage is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			header_count_q <= 4'd0;
			version_q      <= 8'd0;
			type_q         <= 8'd0;
			hdr_len_q      <= 16'd0;
			pay_len_q      <= 16'd0;
			exp_crc_q      <= 32'd0;
			pay_cnt_q      <= 16'd0;
			run_crc_q      <= CRC_INIT;
		end else if (adv) begin
			phase_q        <= phase_d;
			header_count_q <= header_count_d;
			version_q      <= version_d;
			type_q         <= type_d;
			hdr_len_q      <= hdr_len_d;
			pay_len_q      <= pay_len_d;
			exp_crc_q      <= exp_crc_d;
			pay_cnt_q      <= pay_cnt_d;
			run_crc_q      <= run_crc_d;
		end
	end

	// ---------------------------------------------------------------
	// Result register: load a beat when one is produced, drop the
	// held beat once it has been taken.
	// ---------------------------------------------------------------
	logic       out_valid_q;
	event_t     out_ev_q;
	logic [7:0] out_data_q;
	logic       out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (out_valid_q && out_stall) || (adv && res_valid);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_ev_q   <= res_ev;
			out_data_q <= res_data;
			out_last_q <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign event_res = out_ev_q;
	assign data_byte = out_data_q;
	assign last      = out_last_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_last_matches_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_ev_q == EV_LAST_OK || out_ev_q == EV_LAST_CRC)))
		else $error("last flag disagrees with event code");

	a_error_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_ev_q == EV_BAD_SYNC || out_ev_q == EV_BAD_VER ||
		out_ev_q == EV_BAD_LEN) |-> (out_data_q == 8'd0))
		else $error("error beat carries data");

	a_header_position: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HEADER) |-> (header_count_q >= POS_VERSION))
		else $error("header position out of range");

	a_held_byte_stable: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(byte_s1))
		else $error("input stage lost a held byte");

	a_payload_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PAYLOAD) |-> (pay_cnt_q < pay_len_q))
		else $error("payload count ran past frame length");

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for sync_header_crc_frame_receiver: random byte streams of framed,
// damaged and noisy traffic against an in-bench predictor of the parser and payload CRC.
// Depends on shcfr_pkg and the RTL in rtl/.
module tb;
	import shcfr_pkg::*;

	// one result beat as the block should present it
	typedef struct packed {
		event_t     ev;
		logic [7:0] data;
		logic       fin;
	} beat_t;

	// Frame predictor and result store. note_byte advances the predicted parser by one
	// accepted byte; check_beat pops the oldest predicted beat and compares it.
	class frame_scoreboard;
		phase_t      ph;
		logic [3:0]  hpos;
		logic [7:0]  ver, typ;
		logic [15:0] hlen, plen, pcount, max_len;
		logic [31:0] want_crc, crc;
		beat_t       pending_q[$];
		int          mismatches, frames_ok, frames_crc, header_rejects, sync_errors;

		function new();
			ph = PH_HUNT;
			hpos = '0;
			ver = '0;
			typ = '0;
			hlen = '0;
			plen = '0;
			pcount = '0;
			want_crc = '0;
			crc = CRC_INIT;
			max_len = MAX_PAYLOAD_RESET;
		endfunction

		static function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
			logic [31:0] r;
			r = c ^ {24'd0, b};
			for (int i = 0; i < 8; i++)
				r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void set_max(logic [15:0] v);
			max_len = v;
		endfunction

		function void add_beat(event_t ev, logic [7:0] d, logic f);
			beat_t x;
			x.ev = ev;
			x.data = d;
			x.fin = f;
			pending_q.push_back(x);
		endfunction

		function void note_byte(logic [7:0] b);
			case (ph)
				PH_HUNT: begin
					if (b == SYNC_FIRST) begin
						ph = PH_SECOND;
					end else begin
						sync_errors++;
						add_beat(EV_BAD_SYNC, 8'd0, 1'b0);
					end
				end
				PH_SECOND: begin
					if (b == SYNC_SECOND) begin
						ph = PH_HEADER;
						hpos = POS_VERSION;
					end else if (b != SYNC_FIRST) begin
						ph = PH_HUNT;
						sync_errors++;
						add_beat(EV_BAD_SYNC, 8'd0, 1'b0);
					end
				end
				PH_HEADER: begin
					case (hpos)
						POS_VERSION: ver = b;
						POS_TYPE:    typ = b;
						POS_HLEN_LO: hlen[7:0] = b;
						POS_HLEN_HI: hlen[15:8] = b;
						POS_PLEN_LO: plen[7:0] = b;
						POS_PLEN_HI: plen[15:8] = b;
						POS_CRC_B0:  want_crc[7:0] = b;
						POS_CRC_B1:  want_crc[15:8] = b;
						POS_CRC_B2:  want_crc[23:16] = b;
						POS_CRC_B3:  want_crc[31:24] = b;
						default: ;
					endcase
					if (hpos != HDR_LAST_POS) begin
						hpos = hpos + 4'd1;
					end else if (ver != HDR_VERSION || typ != HDR_TYPE) begin
						ph = PH_HUNT;
						header_rejects++;
						add_beat(EV_BAD_VER, 8'd0, 1'b0);
					end else if (hlen != HDR_BYTES || plen < MIN_PAYLOAD || plen > max_len) begin
						ph = PH_HUNT;
						header_rejects++;
						add_beat(EV_BAD_LEN, 8'd0, 1'b0);
					end else begin
						ph = PH_PAYLOAD;
						pcount = '0;
						crc = CRC_INIT;
					end
				end
				default: begin
					crc = crc_step(crc, b);
					pcount = pcount + 16'd1;
					if (pcount < plen) begin
						add_beat(EV_PAYLOAD, b, 1'b0);
					end else begin
						ph = PH_HUNT;
						if (crc == want_crc) begin
							frames_ok++;
							add_beat(EV_LAST_OK, b, 1'b1);
						end else begin
							frames_crc++;
							add_beat(EV_LAST_CRC, b, 1'b1);
						end
					end
				end
			endcase
		endfunction

		task report_mismatch(string what);
			if (mismatches < 20)
				$display("mismatch at %0t: %s", $time, what);
			mismatches++;
		endtask

		task check_beat(logic [2:0] ev, logic [7:0] d, logic f);
			beat_t w;
			if (pending_q.size() == 0) begin
				report_mismatch($sformatf("unexpected beat event %0d data %02h last %0b", ev, d, f));
				return;
			end
			w = pending_q.pop_front();
			if (ev != w.ev)
				report_mismatch($sformatf("event_res %0d, predicted %0d", ev, w.ev));
			if (d != w.data)
				report_mismatch($sformatf("data_byte %02h, predicted %02h", d, w.data));
			if (f != w.fin)
				report_mismatch($sformatf("last %0b, predicted %0b", f, w.fin));
		endtask

		task close_out();
			if (pending_q.size() != 0)
				report_mismatch($sformatf("%0d predicted beats never arrived", pending_q.size()));
		endtask
	endclass

	localparam int SETTLE_CYCLES = 4;    // byte in to result out passes the input and result registers; allow margin
	localparam int WATCHDOG_LIMIT = 3000; // far beyond the longest gap plus the longest stall
	localparam int PHASE_BYTES = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic        last;

	frame_scoreboard sb;
	bit  quiet = 1'b0;   // while set, the sender adds no gaps and no new stall bursts start
	int  bytes_sent = 0;
	int  settings_used = 1;
	int  idle_cycles = 0;
	int  stall_left = 0;

	sync_header_crc_frame_receiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.event_res (event_res),
		.data_byte (data_byte),
		.last      (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then a long one.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Payload length for a frame that should pass: mostly short, a few longer.
	// Stays small even when the register allows far more, to bound the run.
	function logic [15:0] pick_len();
		int top;
		if (sb.max_len < MIN_PAYLOAD)
			return MIN_PAYLOAD;
		top = (sb.max_len < 40) ? int'(sb.max_len) : 40;
		if ($urandom_range(0, 99) < 85)
			return 16'($urandom_range(MIN_PAYLOAD, top));
		top = (sb.max_len < 300) ? int'(sb.max_len) : 300;
		return 16'($urandom_range(MIN_PAYLOAD, top));
	endfunction

	// Result side: take a beat whenever valid is high and stall low, then pick the
	// stall for the next edge. Bursts of stall are drawn like the sender's gaps.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_beat(event_res, data_byte, last);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (!quiet && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left = pick_gap();
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: a run of cycles with no beat on either side means the block has hung.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles", idle_cycles);
			$display("FAIL sync_header_crc_frame_receiver");
			$finish;
		end
	end

	// Offer one byte and hold it until the block takes it; valid stays high afterwards
	// so that back-to-back bytes need no extra assignment.
	task drive_byte(input logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	// Hold the sender until every predicted beat has come out, then let the
	// pipeline empty of bytes that cause no result.
	task drain_results();
		in_valid <= 1'b0;
		while (sb.pending_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_max(input logic [15:0] v);
		drain_results();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_max(v);
		settings_used++;
	endtask

	// Send sync, header and, if the header will pass, a random payload. A cut frame
	// stops early, so the following bytes are taken as payload.
	task send_frame(input logic [7:0] ver, input logic [7:0] typ, input logic [15:0] hlen,
			input logic [15:0] plen, input bit bad_crc, input bit cut);
		logic [7:0]  body[$];
		logic [31:0] crc;
		int          n;
		body.delete();
		crc = CRC_INIT;
		n = 0;
		if (ver == HDR_VERSION && typ == HDR_TYPE && hlen == HDR_BYTES &&
				plen >= MIN_PAYLOAD && plen <= sb.max_len)
			n = int'(plen);
		for (int i = 0; i < n; i++) begin
			body.push_back(8'($urandom));
			crc = frame_scoreboard::crc_step(crc, body[i]);
		end
		if (bad_crc)
			crc[$urandom_range(0, 31)] ^= 1'b1;
		if (cut && n > 0)
			n = $urandom_range(0, n - 1);
		drive_byte(SYNC_FIRST);
		drive_byte(SYNC_SECOND);
		drive_byte(ver);
		drive_byte(typ);
		drive_byte(hlen[7:0]);
		drive_byte(hlen[15:8]);
		drive_byte(plen[7:0]);
		drive_byte(plen[15:8]);
		repeat (4) drive_byte(8'($urandom));   // flags, ignored by the block
		drive_byte(crc[7:0]);
		drive_byte(crc[15:8]);
		drive_byte(crc[23:16]);
		drive_byte(crc[31:24]);
		for (int i = 0; i < n; i++)
			drive_byte(body[i]);
	endtask

	// Length edges for the current register value, with random payloads.
	task edge_frames();
		if (sb.max_len >= MIN_PAYLOAD && sb.max_len <= 300)
			send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, sb.max_len, 1'b0, 1'b0);
		if (sb.max_len != 16'hFFFF)
			send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, sb.max_len + 16'd1, 1'b0, 1'b0);
		send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, MIN_PAYLOAD - 16'd1, 1'b0, 1'b0);
		send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, MIN_PAYLOAD, 1'b1, 1'b0);
	endtask

	// Mostly well-formed frames with random content; the rest is damaged headers,
	// cut frames, line noise and sync pairs followed by a header broken off early.
	task random_traffic(input int count);
		int          stop_at, half, r, n;
		bit          paused;
		logic [7:0]  v, t;
		logic [15:0] hl, pl;
		stop_at = bytes_sent + count;
		half = bytes_sent + count / 2;
		paused = 1'b0;
		while (bytes_sent < stop_at) begin
			if (!paused && bytes_sent >= half) begin
				drain_results();
				paused = 1'b1;
			end
			if ($urandom_range(0, 19) == 0)
				quiet = !quiet;
			r = $urandom_range(0, 99);
			if (r < 60) begin
				send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, pick_len(),
					$urandom_range(0, 3) == 0, 1'b0);
			end else if (r < 68) begin
				send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, pick_len(), 1'b0, 1'b1);
			end else if (r < 76) begin
				v = 8'($urandom);
				t = 8'($urandom);
				case ($urandom_range(0, 2))
					0: v = HDR_VERSION;
					1: t = HDR_TYPE;
					default: ;
				endcase
				if (v == HDR_VERSION && t == HDR_TYPE)
					t = HDR_TYPE + 8'd1;
				hl = $urandom_range(0, 1) ? HDR_BYTES : 16'($urandom);
				pl = $urandom_range(0, 1) ? pick_len() : 16'($urandom);
				send_frame(v, t, hl, pl, 1'b0, 1'b0);
			end else if (r < 84) begin
				hl = HDR_BYTES;
				case ($urandom_range(0, 2))
					0: begin
						hl = 16'($urandom);
						if (hl == HDR_BYTES)
							hl = HDR_BYTES + 16'd1;
						pl = 16'($urandom);
					end
					1: pl = 16'($urandom_range(0, MIN_PAYLOAD - 1));
					default: begin
						if (sb.max_len != 16'hFFFF)
							pl = 16'($urandom_range(int'(sb.max_len) + 1, 65535));
						else
							pl = 16'($urandom_range(0, MIN_PAYLOAD - 1));
					end
				endcase
				send_frame(HDR_VERSION, HDR_TYPE, hl, pl, 1'b0, 1'b0);
			end else if (r < 92) begin
				n = $urandom_range(1, 6);
				repeat (n)
					drive_byte($urandom_range(0, 3) == 0 ? SYNC_FIRST : 8'($urandom));
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) drive_byte(SYNC_FIRST);
				drive_byte(SYNC_SECOND);
				n = $urandom_range(0, 14);
				repeat (n) drive_byte(8'($urandom));
			end
		end
		quiet = 1'b0;
	endtask

	logic [15:0] max_plan[5] = '{16'd82, 16'd14, 16'd13, 16'd0, 16'hFFFF};

	initial begin
		logic [15:0] setting;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hunting: bytes that are not 'V', including a stray 'L'.
		drive_byte(8'h00);
		drive_byte(8'hFF);
		drive_byte(SYNC_SECOND);
		// 'V' then anything but 'L' drops back to hunting.
		drive_byte(SYNC_FIRST);
		drive_byte(8'h41);
		// Repeated 'V' re-syncs; the header then fails both checks, so only the
		// version/type error is expected.
		drive_byte(SYNC_FIRST);
		send_frame(8'h00, 8'h00, 16'h0000, 16'd13, 1'b0, 1'b0);
		send_frame(HDR_VERSION, HDR_TYPE + 8'd1, HDR_BYTES, MIN_PAYLOAD, 1'b0, 1'b0);
		send_frame(HDR_VERSION + 8'd1, HDR_TYPE, HDR_BYTES, MIN_PAYLOAD, 1'b0, 1'b0);
		send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES + 16'd1, MIN_PAYLOAD, 1'b0, 1'b0);
		send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, 16'hFFFF, 1'b0, 1'b0);
		send_frame(HDR_VERSION, HDR_TYPE, HDR_BYTES, MIN_PAYLOAD, 1'b0, 1'b0);

		// Reset value of the register first, then the planned settings and one random.
		edge_frames();
		random_traffic(PHASE_BYTES);
		for (int i = 0; i < 6; i++) begin
			setting = (i < 5) ? max_plan[i] : 16'($urandom_range(82, 65535));
			write_max(setting);
			edge_frames();
			random_traffic(PHASE_BYTES);
		end

		drain_results();
		sb.close_out();
		$display("bytes %0d over %0d register settings: %0d good frames, %0d crc errors",
			bytes_sent, settings_used, sb.frames_ok, sb.frames_crc);
		$display("header rejects %0d, sync errors %0d, mismatches %0d",
			sb.header_rejects, sb.sync_errors, sb.mismatches);
		if (sb.mismatches == 0)
			$display("PASS sync_header_crc_frame_receiver");
		else
			$display("FAIL sync_header_crc_frame_receiver");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/shcfr_pkg.sv
rtl/shcfr_crc_byte.sv
rtl/sync_header_crc_frame_receiver.sv
tb/tb.sv
